/* design/ssc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg - shared types and constants of the six-step commutator
// Event codes, queue entry, result record, configuration set, step tables.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOCK_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCED_PERIOD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_DUTY       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WDOG_HIGH      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WDOG_LOW       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REALIGN_DELAY  = 3'd5;

    localparam logic ACTION_BEMF      = 1'b0;
    localparam logic ACTION_COMMUTATE = 1'b1;

    localparam logic [1:0] PHASE_NONE = 2'd0;
    localparam logic [1:0] PHASE_A    = 2'd1;
    localparam logic [1:0] PHASE_B    = 2'd2;
    localparam logic [1:0] PHASE_C    = 2'd3;

    localparam logic [2:0]  STEP_FIRST     = 3'd1;
    localparam logic [2:0]  STEP_REALIGN   = 3'd6;
    localparam logic [31:0] COMPARE_RESET  = 32'd480000;
    localparam logic [11:0] LEVEL_MAX      = 12'd4095;
    localparam logic [12:0] WINDOW_MARGIN  = 13'd50;
    localparam logic [39:0] FILTER_WEIGHT  = 40'd250;

    localparam logic [31:0] LOCK_THRESHOLD_RESET = 32'hFFFF_FFFF;
    localparam logic [31:0] FORCED_PERIOD_RESET  = 32'd80000;
    localparam logic [15:0] PWM_DUTY_RESET       = 16'd0;
    localparam logic [11:0] WDOG_HIGH_RESET      = 12'd1024;
    localparam logic [11:0] WDOG_LOW_RESET       = 12'd900;
    localparam logic [15:0] REALIGN_DELAY_RESET  = 16'd20;

    typedef struct packed {
        logic [31:0] lock_period_threshold;
        logic [31:0] forced_step_period;
        logic [15:0] pwm_duty;
        logic [11:0] watchdog_high_level;
        logic [11:0] watchdog_low_level;
        logic [15:0] realign_delay;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [11:0] average;
        logic [31:0] timestamp;
    } qentry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic [1:0]  high_side_phase;
        logic [1:0]  low_side_phase;
        logic [15:0] low_side_duty;
        logic [31:0] compare_time;
        logic [31:0] period_out;
        logic        locked_flag;
        logic [11:0] window_upper;
        logic [11:0] window_lower;
    } result_t;

    function automatic logic [1:0] step_high(input logic [2:0] idx);
        case (idx)
            3'd1, 3'd2: step_high = PHASE_A;
            3'd3, 3'd4: step_high = PHASE_B;
            3'd5, 3'd6: step_high = PHASE_C;
            default:    step_high = PHASE_NONE;
        endcase
    endfunction

    function automatic logic [1:0] step_low(input logic [2:0] idx);
        case (idx)
            3'd1:       step_low = PHASE_B;
            3'd2, 3'd3: step_low = PHASE_C;
            3'd4, 3'd5: step_low = PHASE_A;
            3'd6:       step_low = PHASE_B;
            default:    step_low = PHASE_NONE;
        endcase
    endfunction

    function automatic logic [2:0] step_succ(input logic [2:0] idx);
        case (idx)
            3'd1:    step_succ = 3'd2;
            3'd2:    step_succ = 3'd3;
            3'd3:    step_succ = 3'd4;
            3'd4:    step_succ = 3'd5;
            3'd5:    step_succ = 3'd6;
            3'd6:    step_succ = 3'd1;
            default: step_succ = idx;
        endcase
    endfunction

endpackage

/* design/sensorless_six_step_commutator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensorless_six_step_commutator - sensorless six-step BLDC commutation
// Back-EMF zero-crossing tracking, period filtering and gate sequencing.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    action, sample_first, sample_second, timestamp
//  out      out_valid / out_stall  gate phases, duty, compare, period, lock, window
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One event per cycle sustained while out_stall stays low; a result passes from its beat
//  through the queue write at the beat, then the engine's result register.
//  in_stall rises only when the QUEUE_DEPTH-entry queue is full.
//  Reset clears motor state and restores register defaults; cfg_ready stays high.
// ----------------------------------------------------------------------------
module sensorless_six_step_commutator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [11:0]                     sample_first,
    input  logic [11:0]                     sample_second,
    input  logic [31:0]                     timestamp,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      high_side_phase,
    output logic [1:0]                      low_side_phase,
    output logic [15:0]                     low_side_duty,
    output logic [31:0]                     compare_time,
    output logic [31:0]                     period_out,
    output logic                            locked_flag,
    output logic [11:0]                     window_upper,
    output logic [11:0]                     window_lower,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ssc_pkg::cfg_t    cfg_reg;
    ssc_pkg::qstat_t  q_status;
    ssc_pkg::qentry_t q_in;
    ssc_pkg::qentry_t q_head;
    ssc_pkg::result_t res;
    logic             q_push;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lock_period_threshold <= ssc_pkg::LOCK_THRESHOLD_RESET;
            cfg_reg.forced_step_period    <= ssc_pkg::FORCED_PERIOD_RESET;
            cfg_reg.pwm_duty              <= ssc_pkg::PWM_DUTY_RESET;
            cfg_reg.watchdog_high_level   <= ssc_pkg::WDOG_HIGH_RESET;
            cfg_reg.watchdog_low_level    <= ssc_pkg::WDOG_LOW_RESET;
            cfg_reg.realign_delay         <= ssc_pkg::REALIGN_DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssc_pkg::CFG_LOCK_THRESHOLD: cfg_reg.lock_period_threshold <= cfg_data;
                ssc_pkg::CFG_FORCED_PERIOD:  cfg_reg.forced_step_period    <= cfg_data;
                ssc_pkg::CFG_PWM_DUTY:       cfg_reg.pwm_duty      <= cfg_data[15:0];
                ssc_pkg::CFG_WDOG_HIGH:      cfg_reg.watchdog_high_level <= cfg_data[11:0];
                ssc_pkg::CFG_WDOG_LOW:       cfg_reg.watchdog_low_level  <= cfg_data[11:0];
                ssc_pkg::CFG_REALIGN_DELAY:  cfg_reg.realign_delay <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ssc_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .sample_first  (sample_first),
        .sample_second (sample_second),
        .timestamp     (timestamp),
        .q_status      (q_status),
        .push          (q_push),
        .entry         (q_in)
    );

    ssc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_head),
        .status    (q_status)
    );

    ssc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (!q_status.empty),
        .head       (q_head),
        .pop        (q_pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .res        (res)
    );

    assign high_side_phase = res.high_side_phase;
    assign low_side_phase  = res.low_side_phase;
    assign low_side_duty   = res.low_side_duty;
    assign compare_time    = res.compare_time;
    assign period_out      = res.period_out;
    assign locked_flag     = res.locked_flag;
    assign window_upper    = res.window_upper;
    assign window_lower    = res.window_lower;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("engine took an event from an empty queue");

    a_beat_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !q_status.empty)
        else $error("accepted beat missing from queue");

    a_gate_no_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (high_side_phase != ssc_pkg::PHASE_NONE)) |->
        (window_upper == '0 && window_lower == '0))
        else $error("gate pattern and watchdog window in one result");

    a_window_no_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (window_upper != '0)) |->
        (low_side_phase == ssc_pkg::PHASE_NONE && low_side_duty == '0))
        else $error("watchdog window result drives a gate");

endmodule

/* design/ssc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_queue - short event queue between front and back
// Circular buffer of classified events with full and empty status.
// ----------------------------------------------------------------------------
module ssc_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ssc_pkg::qentry_t push_data,
    input  logic             pop,
    output ssc_pkg::qentry_t pop_data,
    output ssc_pkg::qstat_t  status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ssc_pkg::qentry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            wrap_inc = '0;
        else
            wrap_inc = p + PTR_W'(1);
    endfunction

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* design/ssc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_front - event intake
// Accept input beats, average the back-EMF samples, queue the event.
// ----------------------------------------------------------------------------
module ssc_front (
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             action,
    input  logic [11:0]      sample_first,
    input  logic [11:0]      sample_second,
    input  logic [31:0]      timestamp,
    input  ssc_pkg::qstat_t  q_status,
    output logic             push,
    output ssc_pkg::qentry_t entry
);

    logic [12:0] sample_sum;

    assign sample_sum = {1'b0, sample_first} + {1'b0, sample_second};

    assign in_stall        = q_status.full;
    assign push            = in_valid && !q_status.full;
    assign entry.action    = action;
    assign entry.average   = sample_sum[12:1];
    assign entry.timestamp = timestamp;

endmodule

/* design/ssc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_back - commutation engine
// Execute queued events against the motor state and register the result.
// ----------------------------------------------------------------------------
module ssc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ssc_pkg::cfg_t    cfg,
    input  logic             head_valid,
    input  ssc_pkg::qentry_t head,
    output logic             pop,
    input  logic             out_stall,
    output logic             out_valid,
    output ssc_pkg::result_t res
);

    logic [31:0] last_cross_reg, last_cross_next;
    logic [31:0] filt_reg, filt_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] period_reg, period_next;
    logic [31:0] compare_reg, compare_next;
    logic [11:0] thr_reg, thr_next;
    logic        lock_reg, lock_next;
    logic        out_valid_reg, out_valid_next;
    ssc_pkg::result_t res_reg, res_next;

    logic        advance;
    logic        above;
    logic [12:0] lower_sum;
    logic [11:0] lower_sat;
    logic [31:0] delta;
    logic [39:0] acc;
    logic [31:0] filt_new;
    logic [34:0] filt_x6;
    logic        unlocked;

    assign advance   = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = advance;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    assign above     = head.average > thr_reg;
    assign lower_sum = {1'b0, cfg.watchdog_high_level} + ssc_pkg::WINDOW_MARGIN;
    assign lower_sat = lower_sum[12] ? ssc_pkg::LEVEL_MAX : lower_sum[11:0];
    assign delta     = head.timestamp - last_cross_reg;
    assign acc       = ({8'd0, filt_reg} * ssc_pkg::FILTER_WEIGHT) + {8'd0, delta};
    assign filt_new  = acc[39:8];
    assign filt_x6   = ({3'd0, filt_new} << 2) + ({3'd0, filt_new} << 1);
    assign unlocked  = filt_x6 > {3'd0, cfg.lock_period_threshold};

    always_comb
    begin
        last_cross_next = last_cross_reg;
        filt_next       = filt_reg;
        step_next       = step_reg;
        period_next     = period_reg;
        compare_next    = compare_reg;
        thr_next        = thr_reg;
        lock_next       = lock_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (advance)
        begin
            res_next       = '0;
            out_valid_next = 1'b1;
            if (head.action == ssc_pkg::ACTION_COMMUTATE)
            begin
                compare_next = compare_reg + period_reg;
                if (step_reg inside {[3'd1:3'd6]})
                begin
                    res_next.high_side_phase = ssc_pkg::step_high(step_reg);
                    res_next.low_side_phase  = ssc_pkg::step_low(step_reg);
                    res_next.low_side_duty   = cfg.pwm_duty;
                    step_next                = ssc_pkg::step_succ(step_reg);
                end
            end
            else if (above)
            begin
                thr_next              = cfg.watchdog_low_level;
                res_next.window_upper = ssc_pkg::LEVEL_MAX;
                res_next.window_lower = lower_sat;
            end
            else
            begin
                last_cross_next = head.timestamp;
                filt_next       = filt_new;
                if (unlocked)
                begin
                    lock_next    = 1'b0;
                    period_next  = filt_new;
                    step_next    = ssc_pkg::STEP_REALIGN;
                    compare_next = head.timestamp + {16'd0, cfg.realign_delay};
                end
                else
                begin
                    lock_next   = 1'b1;
                    period_next = cfg.forced_step_period;
                end
                res_next.window_upper = cfg.watchdog_high_level;
            end
            res_next.compare_time = compare_next;
            res_next.period_out   = period_next;
            res_next.locked_flag  = lock_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cross_reg <= '0;
            filt_reg       <= '0;
            step_reg       <= ssc_pkg::STEP_FIRST;
            period_reg     <= '0;
            compare_reg    <= ssc_pkg::COMPARE_RESET;
            thr_reg        <= ssc_pkg::WDOG_HIGH_RESET;
            lock_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            last_cross_reg <= last_cross_next;
            filt_reg       <= filt_next;
            step_reg       <= step_next;
            period_reg     <= period_next;
            compare_reg    <= compare_next;
            thr_reg        <= thr_next;
            lock_reg       <= lock_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

/* tb/sensorless_six_step_commutator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensorless_six_step_commutator_test - self-checking bench for the commutator
// A directed table walks reset values, sample and timestamp extremes, the
// threshold edge, the full six-step cycle, unlocked realignment and window
// saturation. Random phases follow, each with its own register set. Event
// streams look like a running motor and are mixed with noise. The sender
// works in bursts and the receiver stalls on its own pattern. Every result
// beat is checked against a table record or a cycle-free commutation model.
// ----------------------------------------------------------------------------
module sensorless_six_step_commutator_test;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int DRAIN_CYCLES    = 6;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int REPORT_LIMIT    = 10;
    localparam int PLAN_LEN        = 27;
    localparam int IDX_W           = ssc_pkg::CFG_INDEX_W;
    localparam int DATA_W          = ssc_pkg::CFG_DATA_W;

    typedef enum logic { ROW_EVENT, ROW_WRITE } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              act;
        logic [11:0]       a;
        logic [11:0]       b;
        logic [31:0]       ts;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
        logic              typed;
        ssc_pkg::result_t  want;
    } plan_row_t;

    localparam ssc_pkg::result_t NO_RECORD = '0;

    localparam logic [IDX_W-1:0] I_LOCK = ssc_pkg::CFG_LOCK_THRESHOLD;
    localparam logic             A_BEMF = ssc_pkg::ACTION_BEMF;
    localparam logic             A_COMM = ssc_pkg::ACTION_COMMUTATE;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              action;
    logic [11:0]       sample_first;
    logic [11:0]       sample_second;
    logic [31:0]       timestamp;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        high_side_phase;
    logic [1:0]        low_side_phase;
    logic [15:0]       low_side_duty;
    logic [31:0]       compare_time;
    logic [31:0]       period_out;
    logic              locked_flag;
    logic [11:0]       window_upper;
    logic [11:0]       window_lower;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;

    logic [31:0] reg_lock_threshold = ssc_pkg::LOCK_THRESHOLD_RESET;
    logic [31:0] reg_forced_period  = ssc_pkg::FORCED_PERIOD_RESET;
    logic [15:0] reg_duty           = ssc_pkg::PWM_DUTY_RESET;
    logic [11:0] reg_level_high     = ssc_pkg::WDOG_HIGH_RESET;
    logic [11:0] reg_level_low      = ssc_pkg::WDOG_LOW_RESET;
    logic [15:0] reg_realign        = ssc_pkg::REALIGN_DELAY_RESET;

    logic [31:0] last_crossing  = '0;
    logic [31:0] period_filter  = '0;
    logic [2:0]  step_pos       = ssc_pkg::STEP_FIRST;
    logic [31:0] step_ticks     = '0;
    logic [31:0] compare_at     = ssc_pkg::COMPARE_RESET;
    logic [11:0] crossing_level = ssc_pkg::WDOG_HIGH_RESET;
    logic        is_locked      = 1'b0;

    logic [1:0] upper_switch [1:6] = '{ssc_pkg::PHASE_A, ssc_pkg::PHASE_A, ssc_pkg::PHASE_B,
                                       ssc_pkg::PHASE_B, ssc_pkg::PHASE_C, ssc_pkg::PHASE_C};
    logic [1:0] lower_switch [1:6] = '{ssc_pkg::PHASE_B, ssc_pkg::PHASE_C, ssc_pkg::PHASE_C,
                                       ssc_pkg::PHASE_A, ssc_pkg::PHASE_A, ssc_pkg::PHASE_B};

    ssc_pkg::result_t commands_due [$];
    plan_row_t        plan [PLAN_LEN];
    int               errors      = 0;
    int               mismatches  = 0;
    int               cycle_count = 0;
    int               burst_left  = 0;
    int               stall_left  = 0;
    int               stall_mode  = 0;
    logic [31:0]      motor_clock = '0;
    int unsigned      pace        = 1000;

    sensorless_six_step_commutator u_top (.*);

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(1, 40);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= 1'b1;
        endcase
    end

    task automatic compute_command(input logic act, input logic [11:0] a,
                                   input logic [11:0] b, input logic [31:0] ts,
                                   output ssc_pkg::result_t rec);
        logic [12:0] sum;
        logic [11:0] avg;
        logic [12:0] lower_edge;
        logic [31:0] dt;
        logic [39:0] acc;
        logic [34:0] six_period;
        rec = '0;
        if (act == ssc_pkg::ACTION_BEMF)
        begin
            sum = {1'b0, a} + {1'b0, b};
            avg = sum[12:1];
            if (avg > crossing_level)
            begin
                lower_edge = {1'b0, reg_level_high} + ssc_pkg::WINDOW_MARGIN;
                crossing_level = reg_level_low;
                rec.window_upper = ssc_pkg::LEVEL_MAX;
                rec.window_lower = (lower_edge > {1'b0, ssc_pkg::LEVEL_MAX}) ?
                                   ssc_pkg::LEVEL_MAX : lower_edge[11:0];
            end
            else
            begin
                dt = ts - last_crossing;
                last_crossing = ts;
                acc = ssc_pkg::FILTER_WEIGHT * {8'd0, period_filter} + {8'd0, dt};
                period_filter = acc[39:8];
                six_period = {3'd0, period_filter} * 35'd6;
                if (six_period > {3'd0, reg_lock_threshold})
                begin
                    is_locked = 1'b0;
                    step_ticks = period_filter;
                    step_pos = ssc_pkg::STEP_REALIGN;
                    compare_at = ts + {16'd0, reg_realign};
                end
                else
                begin
                    is_locked = 1'b1;
                    step_ticks = reg_forced_period;
                end
                rec.window_upper = reg_level_high;
                rec.window_lower = '0;
            end
        end
        else
        begin
            compare_at = compare_at + step_ticks;
            if (step_pos >= 3'd1 && step_pos <= 3'd6)
            begin
                rec.high_side_phase = upper_switch[step_pos];
                rec.low_side_phase = lower_switch[step_pos];
                rec.low_side_duty = reg_duty;
                step_pos = (step_pos == ssc_pkg::STEP_REALIGN) ? ssc_pkg::STEP_FIRST
                                                                : step_pos + 3'd1;
            end
        end
        rec.compare_time = compare_at;
        rec.period_out = step_ticks;
        rec.locked_flag = is_locked;
    endtask

    task automatic send_event(input logic act, input logic [11:0] a, input logic [11:0] b,
                              input logic [31:0] ts, input logic typed,
                              input ssc_pkg::result_t want);
        ssc_pkg::result_t rec;
        int               idle;
        if (burst_left == 0)
        begin
            idle = $urandom_range(0, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
            repeat (idle)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid      <= 1'b1;
        action        <= act;
        sample_first  <= a;
        sample_second <= b;
        timestamp     <= ts;
        do
            @(posedge clk);
        while (in_stall);
        compute_command(act, a, b, ts, rec);
        commands_due.push_back(typed ? want : rec);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (commands_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ssc_pkg::CFG_LOCK_THRESHOLD: reg_lock_threshold = val;
            ssc_pkg::CFG_FORCED_PERIOD:  reg_forced_period  = val;
            ssc_pkg::CFG_PWM_DUTY:       reg_duty           = val[15:0];
            ssc_pkg::CFG_WDOG_HIGH:      reg_level_high     = val[11:0];
            ssc_pkg::CFG_WDOG_LOW:       reg_level_low      = val[11:0];
            ssc_pkg::CFG_REALIGN_DELAY:  reg_realign        = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_event();
        int unsigned pick;
        int unsigned span;
        logic        act;
        logic [11:0] a;
        logic [11:0] b;
        pick = $urandom_range(0, 15);
        act = ssc_pkg::ACTION_COMMUTATE;
        a = 12'($urandom);
        b = 12'($urandom);
        if (pick < 2)
        begin
            act = 1'($urandom_range(0, 1));
        end
        else if (pick < 6)
        begin
            act = ssc_pkg::ACTION_BEMF;
            if (crossing_level != ssc_pkg::LEVEL_MAX)
            begin
                a = 12'($urandom_range(crossing_level + 1, ssc_pkg::LEVEL_MAX));
                b = 12'($urandom_range(crossing_level + 1, ssc_pkg::LEVEL_MAX));
            end
        end
        else if (pick < 10)
        begin
            act = ssc_pkg::ACTION_BEMF;
            a = 12'($urandom_range(0, crossing_level));
            b = 12'($urandom_range(0, crossing_level));
        end
        span = $urandom_range(0, 7);
        if (span == 0)
            motor_clock = $urandom;
        else if (span == 1)
            motor_clock = motor_clock + $urandom_range(0, 255);
        else
            motor_clock = motor_clock + pace + $urandom_range(0, pace / 8);
        send_event(act, a, b, motor_clock, 1'b0, NO_RECORD);
    endtask

    always @(posedge clk)
    begin : check_results
        ssc_pkg::result_t got;
        ssc_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{high_side_phase, low_side_phase, low_side_duty, compare_time,
                    period_out, locked_flag, window_upper, window_lower};
            if (commands_due.size() == 0)
            begin
                errors++;
                $display("result beat with nothing due at cycle %0d", cycle_count);
            end
            else
            begin
                want = commands_due.pop_front();
                if (got !== want)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  want hs %0d ls %0d duty %h cmp %h per %h lock %b win %h/%h",
                                 want.high_side_phase, want.low_side_phase, want.low_side_duty,
                                 want.compare_time, want.period_out, want.locked_flag,
                                 want.window_upper, want.window_lower);
                        $display("  got  hs %0d ls %0d duty %h cmp %h per %h lock %b win %h/%h",
                                 got.high_side_phase, got.low_side_phase, got.low_side_duty,
                                 got.compare_time, got.period_out, got.locked_flag,
                                 got.window_upper, got.window_lower);
                    end
                end
            end
        end
    end

    initial
    begin
        logic [31:0] settings [6];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ssc_pkg::ACTION_BEMF;
        sample_first  = '0;
        sample_second = '0;
        timestamp     = '0;
        cfg_valid     = 1'b0;
        cfg_index     = ssc_pkg::CFG_LOCK_THRESHOLD;
        cfg_data      = '0;

        plan = '{
            '{ROW_EVENT, A_COMM, 12'd0, 12'd0, 32'd0, I_LOCK, 32'd0, 1'b1,
              '{ssc_pkg::PHASE_A, ssc_pkg::PHASE_B, 16'd0, ssc_pkg::COMPARE_RESET, 32'd0,
                1'b0, 12'd0, 12'd0}},
            '{ROW_EVENT, A_BEMF, 12'd4095, 12'd4095, 32'd100, I_LOCK, 32'd0, 1'b1,
              '{ssc_pkg::PHASE_NONE, ssc_pkg::PHASE_NONE, 16'd0, ssc_pkg::COMPARE_RESET,
                32'd0, 1'b0, ssc_pkg::LEVEL_MAX, 12'd1074}},
            '{ROW_EVENT, A_BEMF, 12'd0, 12'd0, 32'hFFFF_FFFF, I_LOCK, 32'd0, 1'b1,
              '{ssc_pkg::PHASE_NONE, ssc_pkg::PHASE_NONE, 16'd0, ssc_pkg::COMPARE_RESET,
                ssc_pkg::FORCED_PERIOD_RESET, 1'b1, ssc_pkg::WDOG_HIGH_RESET, 12'd0}},
            '{ROW_EVENT, A_COMM, 12'd1, 12'd2, 32'd10, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_COMM, 12'hAAA, 12'h555, 32'd20, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_COMM, 12'h555, 12'hAAA, 32'd30, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_COMM, 12'd4095, 12'd0, 32'd40, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_COMM, 12'd0, 12'd4095, 32'd50, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_COMM, 12'd7, 12'd9, 32'd60, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_BEMF, 12'd900, 12'd900, 32'd5, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_BEMF, 12'd900, 12'd902, 32'd777, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_BEMF, 12'd4095, 12'd0, 32'd1000, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_WRITE, A_BEMF, 12'd0, 12'd0, 32'd0, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_WRITE, A_BEMF, 12'd0, 12'd0, 32'd0, ssc_pkg::CFG_REALIGN_DELAY, 32'hFFFF,
              1'b0, NO_RECORD},
            '{ROW_WRITE, A_BEMF, 12'd0, 12'd0, 32'd0, ssc_pkg::CFG_WDOG_HIGH, 32'hFFF,
              1'b0, NO_RECORD},
            '{ROW_WRITE, A_BEMF, 12'd0, 12'd0, 32'd0, ssc_pkg::CFG_PWM_DUTY, 32'hFFFF,
              1'b0, NO_RECORD},
            '{ROW_EVENT, A_BEMF, 12'd0, 12'd0, 32'hFFFF_FFF0, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_BEMF, 12'd4095, 12'd4095, 32'd0, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_COMM, 12'd0, 12'd0, 32'd1, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_COMM, 12'd0, 12'd0, 32'd2, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_WRITE, A_BEMF, 12'd0, 12'd0, 32'd0, ssc_pkg::CFG_FORCED_PERIOD,
              32'hFFFF_FFFF, 1'b0, NO_RECORD},
            '{ROW_WRITE, A_BEMF, 12'd0, 12'd0, 32'd0, I_LOCK, 32'hFFFF_FFFF, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_BEMF, 12'd0, 12'd0, 32'd12345, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_EVENT, A_COMM, 12'd0, 12'd0, 32'd3, I_LOCK, 32'd0, 1'b0, NO_RECORD},
            '{ROW_WRITE, A_BEMF, 12'd0, 12'd0, 32'd0, ssc_pkg::CFG_WDOG_LOW, 32'd0, 1'b0,
              NO_RECORD},
            '{ROW_EVENT, A_BEMF, 12'd4095, 12'd4095, 32'd20000, I_LOCK, 32'd0, 1'b0,
              NO_RECORD},
            '{ROW_EVENT, A_BEMF, 12'd1, 12'd0, 32'd40000, I_LOCK, 32'd0, 1'b0, NO_RECORD}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle();
                program_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                send_event(plan[i].act, plan[i].a, plan[i].b, plan[i].ts, plan[i].typed,
                           plan[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            pace = $urandom_range(1, 1 << 17);
            if (p == 0)
            begin
                foreach (settings[k])
                    settings[k] = '0;
            end
            else if (p == 1)
            begin
                foreach (settings[k])
                    settings[k] = 32'hFFFF_FFFF;
            end
            else
            begin
                settings[ssc_pkg::CFG_LOCK_THRESHOLD] = $urandom_range(0, 1) ?
                    $urandom : $urandom_range(0, pace);
                settings[ssc_pkg::CFG_FORCED_PERIOD]  = $urandom_range(0, 1) ?
                    $urandom : $urandom_range(0, 200000);
                settings[ssc_pkg::CFG_PWM_DUTY]       = $urandom_range(0, 65535);
                settings[ssc_pkg::CFG_WDOG_HIGH]      = $urandom_range(0, 4095);
                settings[ssc_pkg::CFG_WDOG_LOW]       = $urandom_range(0, 4095);
                settings[ssc_pkg::CFG_REALIGN_DELAY]  = $urandom_range(0, 65535);
            end
            settle();
            foreach (settings[k])
                program_reg(IDX_W'(k), settings[k]);
            repeat (ITEMS_PER_PHASE) random_event();
        end

        settle();
        if (errors == 0 && commands_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
